/* rtl/core/orq_pkg.sv */
// Outstanding request tracker: shared types, result kinds and action codes.
// No dependencies; imported by every module of the tracker.
package orq_pkg;

    // Input actions
    localparam logic [1:0] ACT_REQUEST  = 2'd0;
    localparam logic [1:0] ACT_RESPONSE = 2'd1;
    localparam logic [1:0] ACT_TICK     = 2'd2;
    localparam logic [1:0] ACT_CANCEL   = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_SEND      = 3'd0;
    localparam logic [2:0] KIND_DONE      = 3'd1;
    localparam logic [2:0] KIND_MALFORMED = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [2:0] KIND_CANCEL    = 3'd4;
    localparam logic [2:0] KIND_UNMATCHED = 3'd5;
    localparam logic [2:0] KIND_FULL      = 3'd6;

    // Stream widths
    localparam int IN_DATA_W  = 80;  // 74 bits of fields, padded to bytes
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 56;
    localparam int OUT_USER_W = 3;

    // Per-slot timer record held in the timer memory
    typedef struct packed {
        logic [15:0] reload;
        logic [15:0] countdown;
        logic [7:0]  retries;
        logic [7:0]  attempt;
    } timer_t;

    // Tag table write command
    typedef struct packed {
        logic        alloc;
        logic        clear;
        logic [15:0] seq;
        logic [7:0]  svc;
        logic [7:0]  cmd;
    } tag_wr_t;

    // One result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] seq;
        logic [7:0]  svc;
        logic [7:0]  cmd;
        logic [15:0] status;
        logic [7:0]  attempt;
        logic        last;
    } result_t;

    // Sequence increment that skips zero
    function automatic logic [15:0] seq_inc(input logic [15:0] s);
        seq_inc = (s == 16'hFFFF) ? 16'd1 : s + 16'd1;
    endfunction

endpackage

/* rtl/core/orq_timer_mem.sv */
// Timer memory: countdown, reload, retries and attempt per slot.
// One write port, one read port with a registered read; uses orq_pkg.
module orq_timer_mem
    import orq_pkg::*;
#(
    parameter int Depth = 8,
    parameter int AW    = 3
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  timer_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output timer_t        rdata
);

    timer_t mem [Depth];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/orq_tag_table.sv */
// Tag table: valid bits plus sequence, service and command of each slot.
// Parallel compare for sequence use and response match; uses orq_pkg.
module orq_tag_table
    import orq_pkg::*;
#(
    parameter int Depth = 8,
    parameter int IW    = 3
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tag_wr_t       tag_wr,
    input  logic [IW-1:0] wr_idx,
    input  logic [15:0]   cand_seq,
    output logic          in_use,
    input  logic [15:0]   key_seq,
    input  logic [7:0]    key_svc,
    input  logic [7:0]    key_cmd,
    output logic          free_found,
    output logic [IW-1:0] free_idx,
    output logic          hit_found,
    output logic [IW-1:0] hit_idx,
    input  logic [IW-1:0] rd_idx,
    output logic          rd_valid,
    output logic [15:0]   rd_seq,
    output logic [7:0]    rd_svc,
    output logic [7:0]    rd_cmd
);

    logic [Depth-1:0] valid_reg;
    logic [15:0]      seq_reg [Depth];
    logic [7:0]       svc_reg [Depth];
    logic [7:0]       cmd_reg [Depth];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (tag_wr.alloc)
        begin
            valid_reg[wr_idx] <= 1'b1;
        end
        else if (tag_wr.clear)
        begin
            valid_reg[wr_idx] <= 1'b0;
        end
    end

    // Tag payload
    always_ff @(posedge clk)
    begin
        if (tag_wr.alloc)
        begin
            seq_reg[wr_idx] <= tag_wr.seq;
            svc_reg[wr_idx] <= tag_wr.svc;
            cmd_reg[wr_idx] <= tag_wr.cmd;
        end
    end

    // Compares and lowest-index priority picks
    always_comb
    begin
        in_use     = 1'b0;
        free_found = 1'b0;
        free_idx   = '0;
        hit_found  = 1'b0;
        hit_idx    = '0;
        for (int i = Depth - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && seq_reg[i] == cand_seq)
            begin
                in_use = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
            if (valid_reg[i] && seq_reg[i] == key_seq &&
                svc_reg[i] == key_svc && cmd_reg[i] == key_cmd)
            begin
                hit_found = 1'b1;
                hit_idx   = IW'(i);
            end
        end
    end

    // Walk read
    assign rd_valid = valid_reg[rd_idx];
    assign rd_seq   = seq_reg[rd_idx];
    assign rd_svc   = svc_reg[rd_idx];
    assign rd_cmd   = cmd_reg[rd_idx];

endmodule

/* rtl/core/outstanding_request_tracker_top.sv */
// Outstanding request tracker top level: sequencer, result staging, stream ports.
// Instantiates orq_tag_table and orq_timer_mem; uses orq_pkg.
//
// Use: one input transaction on s_axis carries an action in tuser (new request,
// response, tick, cancel all) and the request/response fields in tdata. Each
// input gives zero or more results on m_axis; tlast marks the final result of
// that input, tuser carries the result kind.
// Throughput: one input at a time. A request tries candidate sequence numbers,
// skipping each one that is in use (at most MAX_PENDING - 1, as a slot is free);
// a response is matched against all slots at once; a tick or cancel walks every
// slot, skipping free slots and, for each valid slot, reading the timer memory,
// then doing a read-modify-write.
// Results pass through a one-entry hold stage so that tlast can be set on the
// last one, then an output register; s_axis_tready rises again once the last
// result sits in the output register, even while the receiver stalls.
// A stalled receiver holds the walk at the slot that produced a result.
// Reset: all slots free, sequence counter zero; no clearing pass is needed.
module outstanding_request_tracker_top
    import orq_pkg::*;
#(
    parameter int MAX_PENDING = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // service[7:0] command[15:8] response_sequence[31:16] is_response_type[32]
    // status_present[33] status_word[49:34] timeout_ticks[65:50]
    // retry_limit[73:66], zero pad [79:74]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // action[1:0]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // seq_number[15:0] out_service[23:16] out_command[31:24]
    // out_status[47:32] attempt_count[55:48]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind[2:0]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int IW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int CW = $clog2(MAX_PENDING + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_RESP,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FLUSH
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    action_reg;
    logic [7:0]    svc_reg;
    logic [7:0]    cmd_reg;
    logic [15:0]   rseq_reg;
    logic          isresp_reg;
    logic          stpres_reg;
    logic [15:0]   status_reg;
    logic [15:0]   tmo_reg;
    logic [7:0]    retry_reg;
    logic [15:0]   cand_reg, cand_next;
    logic [15:0]   nseq_reg, nseq_next;
    logic [IW-1:0] slot_reg, slot_next;
    logic [CW-1:0] idx_reg, idx_next;
    result_t       hold_reg, hold_next;
    logic          hold_valid_reg, hold_valid_next;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          in_accept;
    logic          out_can;
    tag_wr_t       tag_wr;
    logic [IW-1:0] tag_wr_idx;
    logic          in_use;
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic          hit_found;
    logic [IW-1:0] hit_idx;
    logic          rd_valid;
    logic [15:0]   rd_seq;
    logic [7:0]    rd_svc;
    logic [7:0]    rd_cmd;
    logic          mem_we;
    timer_t        mem_wdata;
    logic          mem_re;
    timer_t        mem_rdata;
    logic [IW-1:0] walk_idx;
    logic          walk_done;
    logic          expire;
    logic          emit;
    logic          stall;
    result_t       ev_res;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_can   = !out_valid_reg || m_axis_tready;
    assign walk_idx  = idx_reg[IW-1:0];
    assign walk_done = (idx_reg == CW'(MAX_PENDING));

    orq_tag_table #(
        .Depth (MAX_PENDING),
        .IW    (IW)
    ) u_tags (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag_wr     (tag_wr),
        .wr_idx     (tag_wr_idx),
        .cand_seq   (cand_reg),
        .in_use     (in_use),
        .key_seq    (rseq_reg),
        .key_svc    (svc_reg),
        .key_cmd    (cmd_reg),
        .free_found (free_found),
        .free_idx   (free_idx),
        .hit_found  (hit_found),
        .hit_idx    (hit_idx),
        .rd_idx     (walk_idx),
        .rd_valid   (rd_valid),
        .rd_seq     (rd_seq),
        .rd_svc     (rd_svc),
        .rd_cmd     (rd_cmd)
    );

    orq_timer_mem #(
        .Depth (MAX_PENDING),
        .AW    (IW)
    ) u_timers (
        .clk   (clk),
        .we    (mem_we),
        .waddr (tag_wr_idx),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (walk_idx),
        .rdata (mem_rdata)
    );

    // Tick evaluation of the slot just read
    assign expire = (mem_rdata.countdown <= 16'd1);
    assign emit   = (action_reg == ACT_CANCEL) || expire;
    assign stall  = emit && hold_valid_reg && !out_can;

    always_comb
    begin
        ev_res         = '0;
        ev_res.seq     = rd_seq;
        ev_res.svc     = rd_svc;
        ev_res.cmd     = rd_cmd;
        if (action_reg == ACT_CANCEL)
        begin
            ev_res.kind = KIND_CANCEL;
        end
        else if (mem_rdata.retries != 8'd0)
        begin
            ev_res.kind    = KIND_SEND;
            ev_res.attempt = mem_rdata.attempt + 8'd1;
        end
        else
        begin
            ev_res.kind = KIND_TIMEOUT;
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        nseq_next       = nseq_reg;
        slot_next       = slot_reg;
        idx_next        = idx_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        tag_wr          = '0;
        tag_wr_idx      = walk_idx;
        mem_we          = 1'b0;
        mem_wdata       = mem_rdata;
        mem_re          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cand_next = seq_inc(nseq_reg);
                    slot_next = free_idx;
                    idx_next  = '0;
                    case (s_axis_tuser)
                        ACT_REQUEST:
                        begin
                            if (free_found)
                            begin
                                state_next = ST_ALLOC;
                            end
                            else
                            begin
                                hold_next        = '0;
                                hold_next.kind   = KIND_FULL;
                                hold_next.svc    = s_axis_tdata[7:0];
                                hold_next.cmd    = s_axis_tdata[15:8];
                                hold_valid_next  = 1'b1;
                                state_next       = ST_FLUSH;
                            end
                        end
                        ACT_RESPONSE: state_next = ST_RESP;
                        default:      state_next = ST_WALK_RD;
                    endcase
                end
            end

            // One candidate sequence number per cycle
            ST_ALLOC:
            begin
                if (in_use)
                begin
                    cand_next = seq_inc(cand_reg);
                end
                else
                begin
                    nseq_next         = cand_reg;
                    tag_wr.alloc      = 1'b1;
                    tag_wr.seq        = cand_reg;
                    tag_wr.svc        = svc_reg;
                    tag_wr.cmd        = cmd_reg;
                    tag_wr_idx        = slot_reg;
                    mem_we            = 1'b1;
                    mem_wdata.reload  = tmo_reg;
                    mem_wdata.countdown = tmo_reg;
                    mem_wdata.retries = retry_reg;
                    mem_wdata.attempt = 8'd0;
                    hold_next         = '0;
                    hold_next.kind    = KIND_SEND;
                    hold_next.seq     = cand_reg;
                    hold_next.svc     = svc_reg;
                    hold_next.cmd     = cmd_reg;
                    hold_valid_next   = 1'b1;
                    state_next        = ST_FLUSH;
                end
            end

            ST_RESP:
            begin
                hold_next      = '0;
                hold_next.seq  = rseq_reg;
                hold_next.svc  = svc_reg;
                hold_next.cmd  = cmd_reg;
                if (isresp_reg && hit_found)
                begin
                    tag_wr.clear = 1'b1;
                    tag_wr_idx   = hit_idx;
                    if (stpres_reg)
                    begin
                        hold_next.kind   = KIND_DONE;
                        hold_next.status = status_reg;
                    end
                    else
                    begin
                        hold_next.kind = KIND_MALFORMED;
                    end
                end
                else
                begin
                    hold_next.kind = KIND_UNMATCHED;
                end
                hold_valid_next = 1'b1;
                state_next      = ST_FLUSH;
            end

            // Skip free slots, read timers of valid ones
            ST_WALK_RD:
            begin
                if (walk_done)
                begin
                    state_next = ST_FLUSH;
                end
                else if (rd_valid)
                begin
                    mem_re     = 1'b1;
                    state_next = ST_WALK_EV;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end

            // Read-modify-write of one slot
            ST_WALK_EV:
            begin
                if (!stall)
                begin
                    if (action_reg == ACT_TICK)
                    begin
                        mem_we = 1'b1;
                        if (!expire)
                        begin
                            mem_wdata.countdown = mem_rdata.countdown - 16'd1;
                        end
                        else
                        begin
                            mem_wdata.countdown = mem_rdata.reload;
                            mem_wdata.retries   = mem_rdata.retries - 8'd1;
                            mem_wdata.attempt   = mem_rdata.attempt + 8'd1;
                        end
                    end
                    if (emit && ev_res.kind != KIND_SEND)
                    begin
                        mem_we       = 1'b0;
                        tag_wr.clear = 1'b1;
                    end
                    if (emit)
                    begin
                        if (hold_valid_reg)
                        begin
                            out_next       = hold_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        hold_next       = ev_res;
                        hold_valid_next = 1'b1;
                    end
                    idx_next   = idx_reg + CW'(1);
                    state_next = ST_WALK_RD;
                end
            end

            // Last result of the run goes out with tlast
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_can)
                begin
                    out_next        = hold_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            nseq_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            nseq_reg       <= nseq_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= s_axis_tuser;
            svc_reg    <= s_axis_tdata[7:0];
            cmd_reg    <= s_axis_tdata[15:8];
            rseq_reg   <= s_axis_tdata[31:16];
            isresp_reg <= s_axis_tdata[32];
            stpres_reg <= s_axis_tdata[33];
            status_reg <= s_axis_tdata[49:34];
            tmo_reg    <= s_axis_tdata[65:50];
            retry_reg  <= s_axis_tdata[73:66];
        end
        cand_reg <= cand_next;
        slot_reg <= slot_next;
        idx_reg  <= idx_next;
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    // Ports
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.attempt, out_reg.status, out_reg.cmd,
                            out_reg.svc, out_reg.seq};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;

endmodule

/* rtl/core/orq_checker.sv */
// Port-level checks of the outstanding request tracker, bound to the top level.
// Uses orq_pkg.
module orq_checker
    import orq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser,
    input logic                  m_axis_tlast
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One input at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while busy");

    // Refused request: sequence zero, single result
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FULL |->
            m_axis_tdata[15:0] == 16'd0 && m_axis_tlast)
        else $error("bad table full result");

    // Only send results carry an attempt number
    a_attempt: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != KIND_SEND |-> m_axis_tdata[55:48] == 8'd0)
        else $error("attempt on non-send result");

endmodule

bind outstanding_request_tracker_top orq_checker u_orq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

/* sim/tb.sv */
// Testbench for the outstanding request tracker: random and directed stream traffic,
// a cycle-free model of the slot table, and a scoreboard of results.
// Depends on orq_pkg and outstanding_request_tracker_top.
`timescale 1ns / 100ps

module tb;
    import orq_pkg::*;

    localparam int SLOTS = 8;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  svc;
        logic [7:0]  cmd;
        logic [15:0] rseq;
        logic        is_resp;
        logic        has_status;
        logic [15:0] status;
        logic [15:0] tmo;
        logic [7:0]  retries;
    } req_item_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    // Latched handshake of the last rising edge, for the driver's pop
    logic s_axis_tready_q = 1'b0;
    int hold_count = 0;

    outstanding_request_tracker_top #(.MAX_PENDING(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // Tracker state mirror
    logic        mv_valid [SLOTS];
    logic [15:0] mv_seq [SLOTS];
    logic [7:0]  mv_svc [SLOTS];
    logic [7:0]  mv_cmd [SLOTS];
    logic [15:0] mv_reload [SLOTS];
    logic [15:0] mv_count [SLOTS];
    logic [7:0]  mv_retries [SLOTS];
    logic [7:0]  mv_attempt [SLOTS];
    logic [15:0] mv_next_seq;

    // Generation-time view of the table, updated as items are queued
    logic        mv_valid_shadow [SLOTS];
    logic [15:0] seq_shadow [SLOTS];
    logic [7:0]  svc_shadow [SLOTS];
    logic [7:0]  cmd_shadow [SLOTS];

    req_item_t pending_items[$];
    result_t   expected_results[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    bit stimulus_done = 0;
    bit sender_idle_ok = 1;
    bit long_hold = 0;
    bit quiet_phase = 0;

    task automatic push_result(input logic [2:0] k, input logic [15:0] s,
                               input logic [7:0] sv, input logic [7:0] cm,
                               input logic [15:0] st, input logic [7:0] at);
        result_t r;
        r.kind = k; r.seq = s; r.svc = sv; r.cmd = cm;
        r.status = st; r.attempt = at; r.last = 1'b0;
        expected_results.push_back(r);
    endtask

    function automatic bit seq_busy(input logic [15:0] s);
        for (int i = 0; i < SLOTS; i++)
            if (mv_valid[i] && mv_seq[i] == s) return 1;
        return 0;
    endfunction

    // Predict the results of one accepted input transaction
    task automatic track_item(input req_item_t it);
        int free_slot;
        int hit;
        int before_n;
        free_slot = -1;
        hit = -1;
        before_n = expected_results.size();
        case (it.action)
            ACT_REQUEST:
            begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!mv_valid[i]) free_slot = i;
                if (free_slot < 0)
                    push_result(KIND_FULL, 16'd0, it.svc, it.cmd, 16'd0, 8'd0);
                else
                begin
                    do
                    begin
                        mv_next_seq = mv_next_seq + 16'd1;
                        if (mv_next_seq == 16'd0) mv_next_seq = 16'd1;
                    end while (seq_busy(mv_next_seq));
                    mv_valid[free_slot] = 1'b1;
                    mv_seq[free_slot] = mv_next_seq;
                    mv_svc[free_slot] = it.svc;
                    mv_cmd[free_slot] = it.cmd;
                    mv_reload[free_slot] = it.tmo;
                    mv_count[free_slot] = it.tmo;
                    mv_retries[free_slot] = it.retries;
                    mv_attempt[free_slot] = 8'd0;
                    push_result(KIND_SEND, mv_next_seq, it.svc, it.cmd, 16'd0, 8'd0);
                end
            end
            ACT_RESPONSE:
            begin
                if (it.is_resp)
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (mv_valid[i] && mv_seq[i] == it.rseq && mv_svc[i] == it.svc
                            && mv_cmd[i] == it.cmd) hit = i;
                if (hit < 0)
                    push_result(KIND_UNMATCHED, it.rseq, it.svc, it.cmd, 16'd0, 8'd0);
                else
                begin
                    if (it.has_status)
                        push_result(KIND_DONE, it.rseq, it.svc, it.cmd, it.status, 8'd0);
                    else
                        push_result(KIND_MALFORMED, it.rseq, it.svc, it.cmd, 16'd0, 8'd0);
                    mv_valid[hit] = 1'b0;
                end
            end
            ACT_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!mv_valid[i]) continue;
                    if (mv_count[i] > 16'd1)
                        mv_count[i] = mv_count[i] - 16'd1;
                    else if (mv_retries[i] > 8'd0)
                    begin
                        mv_retries[i] = mv_retries[i] - 8'd1;
                        mv_attempt[i] = mv_attempt[i] + 8'd1;
                        mv_count[i] = mv_reload[i];
                        push_result(KIND_SEND, mv_seq[i], mv_svc[i], mv_cmd[i], 16'd0,
                                    mv_attempt[i]);
                    end
                    else
                    begin
                        mv_valid[i] = 1'b0;
                        push_result(KIND_TIMEOUT, mv_seq[i], mv_svc[i], mv_cmd[i], 16'd0,
                                    8'd0);
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < SLOTS; i++)
                    if (mv_valid[i])
                    begin
                        mv_valid[i] = 1'b0;
                        push_result(KIND_CANCEL, mv_seq[i], mv_svc[i], mv_cmd[i], 16'd0,
                                    8'd0);
                    end
            end
        endcase
        if (expected_results.size() > before_n)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Random item of a given action; responses often hit a live sequence
    function automatic req_item_t rand_item(input logic [1:0] act);
        req_item_t it;
        logic [95:0] rnd;
        int pick;
        rnd = {$urandom, $urandom, $urandom};
        it = rnd[$bits(req_item_t)-1:0];
        it.action = act;
        if (act == ACT_REQUEST)
        begin
            it.svc = 8'($urandom_range(0, 3));
            it.cmd = 8'($urandom_range(0, 3));
            it.tmo = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
            it.retries = ($urandom_range(0, 9) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, 2));
        end
        if (act == ACT_RESPONSE && $urandom_range(0, 3) != 0)
        begin
            pick = $urandom_range(0, SLOTS - 1);
            if (mv_valid_shadow[pick])
            begin
                it.rseq = seq_shadow[pick];
                it.svc = svc_shadow[pick];
                it.cmd = cmd_shadow[pick];
                it.is_resp = ($urandom_range(0, 7) != 0);
            end
        end
        return it;
    endfunction

    task automatic sync_shadow();
        for (int i = 0; i < SLOTS; i++)
        begin
            mv_valid_shadow[i] = mv_valid[i];
            seq_shadow[i] = mv_seq[i];
            svc_shadow[i] = mv_svc[i];
            cmd_shadow[i] = mv_cmd[i];
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Driver: offers queued items, changes at the falling edge
    always @(negedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready_q)
        begin
            void'(pending_items.pop_front());
        end
        if (rst_n && pending_items.size() > 0 && sender_idle_ok &&
            (quiet_phase || $urandom_range(0, 99) >= 16))
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tuser <= pending_items[0].action;
            s_axis_tdata <= {6'd0, pending_items[0].retries, pending_items[0].tmo,
                             pending_items[0].status, pending_items[0].has_status,
                             pending_items[0].is_resp, pending_items[0].rseq,
                             pending_items[0].cmd, pending_items[0].svc};
        end
        else if (!(s_axis_tvalid && !s_axis_tready_q))
            s_axis_tvalid <= 1'b0;
    end

    // Input monitor: predict on each accepted input
    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tready && s_axis_tvalid;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            track_item(pending_items[0]);
            items_sent++;
        end
    end

    // Receiver backpressure, with one long hold-off counted here
    always @(negedge clk)
    begin
        if (long_hold && hold_count < 400)
        begin
            hold_count++;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= quiet_phase || ($urandom_range(0, 99) >= 16);
    end

    // Output monitor: compare against the oldest expectation
    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind=%0d seq=%0d", m_axis_tuser, m_axis_tdata[15:0]);
                errors++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_axis_tuser !== exp_r.kind)
                begin
                    $error("kind expected %0d actual %0d", exp_r.kind, m_axis_tuser); errors++;
                end
                if (m_axis_tdata[15:0] !== exp_r.seq)
                begin
                    $error("seq_number expected %0d actual %0d", exp_r.seq,
                           m_axis_tdata[15:0]); errors++;
                end
                if (m_axis_tdata[23:16] !== exp_r.svc)
                begin
                    $error("out_service expected %0d actual %0d", exp_r.svc,
                           m_axis_tdata[23:16]); errors++;
                end
                if (m_axis_tdata[31:24] !== exp_r.cmd)
                begin
                    $error("out_command expected %0d actual %0d", exp_r.cmd,
                           m_axis_tdata[31:24]); errors++;
                end
                if (m_axis_tdata[47:32] !== exp_r.status)
                begin
                    $error("out_status expected %0d actual %0d", exp_r.status,
                           m_axis_tdata[47:32]); errors++;
                end
                if (m_axis_tdata[55:48] !== exp_r.attempt)
                begin
                    $error("attempt_count expected %0d actual %0d", exp_r.attempt,
                           m_axis_tdata[55:48]); errors++;
                end
                if (m_axis_tlast !== exp_r.last)
                begin
                    $error("last_of_run expected %0d actual %0d", exp_r.last,
                           m_axis_tlast); errors++;
                end
            end
        end
    end

    // Queue an item for the driver
    task automatic queue_item(input req_item_t it);
        pending_items.push_back(it);
    endtask

    // Wait for the driver queue and all results to drain
    task automatic drain_all();
        while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk);
        while (expected_results.size() > 0) @(posedge clk);
        repeat (40) @(posedge clk);
        sync_shadow();
    endtask

    // Stimulus
    initial
    begin
        req_item_t it;
        int r;
        rst_n = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            mv_valid[i] = 0; mv_seq[i] = 0; mv_svc[i] = 0; mv_cmd[i] = 0;
            mv_reload[i] = 0; mv_count[i] = 0; mv_retries[i] = 0; mv_attempt[i] = 0;
        end
        mv_next_seq = 16'd0;
        sync_shadow();
        repeat (7) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // Directed: idle tick and empty cancel, then fill past full
        queue_item(rand_item(ACT_TICK));
        queue_item(rand_item(ACT_CANCEL));
        it = rand_item(ACT_REQUEST); it.svc = 8'hFF; it.cmd = 8'hFF;
        it.tmo = 16'hFFFF; it.retries = 8'hFF; queue_item(it);
        it = rand_item(ACT_REQUEST); it.svc = 8'h00; it.cmd = 8'h00;
        it.tmo = 16'd0; it.retries = 8'd0; queue_item(it);
        it.tmo = 16'd1; it.retries = 8'd1; queue_item(it);
        it.tmo = 16'd2; it.retries = 8'd2; queue_item(it);
        for (int i = 0; i < 5; i++) queue_item(rand_item(ACT_REQUEST));
        drain_all();
        // Responses: done, malformed, wrong type, unmatched
        it = rand_item(ACT_RESPONSE); it.is_resp = 1; it.has_status = 1;
        it.rseq = seq_shadow[0]; it.svc = svc_shadow[0]; it.cmd = cmd_shadow[0];
        it.status = 16'hFFFF; queue_item(it);
        it.rseq = seq_shadow[1]; it.svc = svc_shadow[1]; it.cmd = cmd_shadow[1];
        it.has_status = 0; queue_item(it);
        it.rseq = seq_shadow[2]; it.svc = svc_shadow[2]; it.cmd = cmd_shadow[2];
        it.is_resp = 0; queue_item(it);
        it.is_resp = 1; it.rseq = 16'd0; queue_item(it);
        for (int i = 0; i < 4; i++) queue_item(rand_item(ACT_TICK));
        queue_item(rand_item(ACT_CANCEL));
        drain_all();

        // Random phase, with a long receiver hold and a quiet stretch
        for (int n = 0; n < 180; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) it = rand_item(ACT_REQUEST);
            else if (r < 70) it = rand_item(ACT_RESPONSE);
            else if (r < 95) it = rand_item(ACT_TICK);
            else it = rand_item(ACT_CANCEL);
            queue_item(it);
            if (n == 60) long_hold = 1;
            if (n == 100) quiet_phase = 1;
            if (n == 140) quiet_phase = 0;
            if (n % 12 == 11) drain_all();
            else
            begin
                while (pending_items.size() > 0 || s_axis_tvalid) @(posedge clk);
                sync_shadow();
            end
        end
        drain_all();
        repeat (100) @(posedge clk);
        $display("Run covered %0d input transactions and %0d results,", items_sent,
                 results_seen);
        $display("including table full, resend, timeout, cancel and stalls.");
        if (errors == 0 && expected_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Timeout guard
    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end
endmodule
